FILE: sv/bcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_pkg
// Types and constants shared by the battery cell monitor modules.
// ----------------------------------------------------------------------------
package bcm_pkg;

  localparam int unsigned NUM_ADC   = 8;
  localparam int unsigned NUM_CELLS = 6;
  localparam int unsigned REG_IDX   = 6;
  localparam int unsigned BAT_IDX   = 7;

  // floor(3300*adc/4095) == (adc * MV_RECIP) >> MV_SHIFT for every 12-bit adc
  localparam logic [27:0] MV_RECIP = 28'd216321820;
  localparam int unsigned MV_SHIFT = 28;

  localparam logic [12:0] ABSENT_MV = 13'd100;
  localparam logic [5:0]  BAT_STEP  = 6'd10;

  localparam logic [2:0] LVL_CUTOFF = 3'd0;
  localparam logic [2:0] LVL_20     = 3'd1;
  localparam logic [2:0] LVL_40     = 3'd2;
  localparam logic [2:0] LVL_60     = 3'd3;
  localparam logic [2:0] LVL_80     = 3'd4;
  localparam logic [2:0] LVL_FULL   = 3'd5;

  localparam logic [1:0] LED_OFF    = 2'd0;
  localparam logic [1:0] LED_RED    = 2'd1;
  localparam logic [1:0] LED_GREEN  = 2'd2;
  localparam logic [1:0] LED_ORANGE = 2'd3;

  localparam logic [2:0] REG_ROUT   = 3'd0;
  localparam logic [2:0] REG_CUTOFF = 3'd1;
  localparam logic [2:0] REG_LVL20  = 3'd2;
  localparam logic [2:0] REG_LVL40  = 3'd3;
  localparam logic [2:0] REG_LVL60  = 3'd4;
  localparam logic [2:0] REG_LVL80  = 3'd5;

  typedef struct packed {
    logic [11:0] cell1_adc;
    logic [11:0] cell2_adc;
    logic [11:0] cell3_adc;
    logic [11:0] cell4_adc;
    logic [11:0] cell5_adc;
    logic [11:0] cell6_adc;
    logic [11:0] reg_current_adc;
    logic [11:0] bat_current_adc;
  } in_t;

  typedef struct packed {
    logic [12:0] cell1_mv;
    logic [12:0] cell2_mv;
    logic [12:0] cell3_mv;
    logic [12:0] cell4_mv;
    logic [12:0] cell5_mv;
    logic [12:0] cell6_mv;
    logic [12:0] reg_current_ma;
    logic [17:0] bat_current_ma;
    logic [2:0]  lowest_level;
    logic        cutoff;
    logic [1:0]  led_a;
    logic [1:0]  led_b;
  } out_t;

  typedef struct packed {
    logic [1:0]  rout_select;
    logic [12:0] cutoff_mv;
    logic [12:0] level20_mv;
    logic [12:0] level40_mv;
    logic [12:0] level60_mv;
    logic [12:0] level80_mv;
  } cfg_t;

  typedef struct packed {
    logic [2:0] lowest_level;
    logic       cutoff;
    logic [1:0] led_a;
    logic [1:0] led_b;
  } status_t;

endpackage

FILE: sv/bcm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_stream_if
// Valid/ready channel carrying one payload word per request.
// ----------------------------------------------------------------------------
interface bcm_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

FILE: sv/battery_cell_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_cell_monitor
// Throughput: one request per cycle while the result is not stalled; the
// eight conversion lanes each hold one multiplier stage, followed by the
// result register, and a stalled result holds both stages and the input.
// Reset: asynchronous, active low; pipeline empty, thresholds at defaults.
// ----------------------------------------------------------------------------
module battery_cell_monitor import bcm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bcm_stream_if.sink   in_i,
  bcm_stream_if.source out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t        cfg_q, cfg_d;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  logic        en;
  logic        s1_valid_q, s1_valid_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  logic [11:0] adc [NUM_ADC];
  logic [11:0] mv [NUM_ADC];
  logic [12:0] cell_mv [NUM_CELLS];
  logic [2:0]  level [NUM_CELLS];
  status_t     status;
  logic [5:0]  bat_scale;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROUT:   cfg_d.rout_select = pwdata[1:0];
        REG_CUTOFF: cfg_d.cutoff_mv   = pwdata[12:0];
        REG_LVL20:  cfg_d.level20_mv  = pwdata[12:0];
        REG_LVL40:  cfg_d.level40_mv  = pwdata[12:0];
        REG_LVL60:  cfg_d.level60_mv  = pwdata[12:0];
        REG_LVL80:  cfg_d.level80_mv  = pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROUT:   prdata = {30'd0, cfg_q.rout_select};
      REG_CUTOFF: prdata = {19'd0, cfg_q.cutoff_mv};
      REG_LVL20:  prdata = {19'd0, cfg_q.level20_mv};
      REG_LVL40:  prdata = {19'd0, cfg_q.level40_mv};
      REG_LVL60:  prdata = {19'd0, cfg_q.level60_mv};
      REG_LVL80:  prdata = {19'd0, cfg_q.level80_mv};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rout_select <= 2'd0;
      cfg_q.cutoff_mv   <= 13'd3300;
      cfg_q.level20_mv  <= 13'd3500;
      cfg_q.level40_mv  <= 13'd3650;
      cfg_q.level60_mv  <= 13'd3800;
      cfg_q.level80_mv  <= 13'd3950;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline control: both stages move together unless the result stalls
  assign en          = ~out_valid_q | out_o.ready;
  assign in_i.ready  = en;
  assign s1_valid_d  = en ? in_i.valid : s1_valid_q;
  assign out_valid_d = en ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stage 1: conversion lanes
  assign adc[0]       = in_i.data.cell1_adc;
  assign adc[1]       = in_i.data.cell2_adc;
  assign adc[2]       = in_i.data.cell3_adc;
  assign adc[3]       = in_i.data.cell4_adc;
  assign adc[4]       = in_i.data.cell5_adc;
  assign adc[5]       = in_i.data.cell6_adc;
  assign adc[REG_IDX] = in_i.data.reg_current_adc;
  assign adc[BAT_IDX] = in_i.data.bat_current_adc;

  for (genvar g = 0; g < NUM_ADC; g++) begin : g_conv
    bcm_conv u_conv (
      .clk_i (clk_i),
      .en_i  (en),
      .adc_i (adc[g]),
      .mv_o  (mv[g])
    );
  end

  // stage 2: cell lanes, merge, currents
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    bcm_classify u_classify (
      .mv_i      (mv[g]),
      .cfg_i     (cfg_q),
      .cell_mv_o (cell_mv[g]),
      .level_o   (level[g])
    );
  end

  bcm_merge u_merge (
    .level_i  (level),
    .status_o (status)
  );

  // Rout 10200/5100/3400/2550 gives 10/20/30/40 mA per mV
  assign bat_scale = BAT_STEP * ({4'd0, cfg_q.rout_select} + 6'd1);

  always_comb begin
    out_d.cell1_mv       = cell_mv[0];
    out_d.cell2_mv       = cell_mv[1];
    out_d.cell3_mv       = cell_mv[2];
    out_d.cell4_mv       = cell_mv[3];
    out_d.cell5_mv       = cell_mv[4];
    out_d.cell6_mv       = cell_mv[5];
    out_d.reg_current_ma = {mv[REG_IDX], 1'b0};
    out_d.bat_current_ma = 18'(mv[BAT_IDX]) * 18'(bat_scale);
    out_d.lowest_level   = status.lowest_level;
    out_d.cutoff         = status.cutoff;
    out_d.led_a          = status.led_a;
    out_d.led_b          = status.led_b;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // checks
  a_cutoff_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.cutoff == (out_o.data.lowest_level == LVL_CUTOFF)))
    else $error("cutoff flag disagrees with lowest level");

  a_cutoff_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.cutoff) |->
      (out_o.data.led_a == LED_OFF && out_o.data.led_b == LED_OFF))
    else $error("LEDs lit during cutoff");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("request accepted while result stalled");

  a_stage_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && en) |=> out_o.valid)
    else $error("converted request lost between stages");

endmodule

FILE: sv/bcm_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_conv
// One conversion lane: raw 12-bit ADC sample to millivolts, registered.
// ----------------------------------------------------------------------------
module bcm_conv import bcm_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [11:0] adc_i,
  output logic [11:0] mv_o
);

  logic [39:0] prod;
  logic [11:0] mv_d, mv_q;

  assign prod = 40'(adc_i) * 40'(MV_RECIP);
  assign mv_d = prod[MV_SHIFT +: 12];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mv_q <= mv_d;
    end
  end

  assign mv_o = mv_q;

endmodule

FILE: sv/bcm_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_classify
// One cell lane: divider-corrected cell voltage and its charge level.
// ----------------------------------------------------------------------------
module bcm_classify import bcm_pkg::*; (
  input  logic [11:0] mv_i,
  input  cfg_t        cfg_i,
  output logic [12:0] cell_mv_o,
  output logic [2:0]  level_o
);

  logic [13:0] triple;

  assign triple    = {2'b00, mv_i} + {1'b0, mv_i, 1'b0};
  assign cell_mv_o = triple[13:1];

  always_comb begin
    if (cell_mv_o < ABSENT_MV) begin
      level_o = LVL_FULL;   // absent cell
    end else if (cell_mv_o <= cfg_i.cutoff_mv) begin
      level_o = LVL_CUTOFF;
    end else if (cell_mv_o <= cfg_i.level20_mv) begin
      level_o = LVL_20;
    end else if (cell_mv_o <= cfg_i.level40_mv) begin
      level_o = LVL_40;
    end else if (cell_mv_o <= cfg_i.level60_mv) begin
      level_o = LVL_60;
    end else if (cell_mv_o <= cfg_i.level80_mv) begin
      level_o = LVL_80;
    end else begin
      level_o = LVL_FULL;
    end
  end

endmodule

FILE: sv/bcm_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcm_merge
// Combines the cell lane levels: lowest level, cutoff flag and LED codes.
// ----------------------------------------------------------------------------
module bcm_merge import bcm_pkg::*; (
  input  logic [2:0] level_i [NUM_CELLS],
  output status_t    status_o
);

  logic [2:0] lowest;

  always_comb begin
    lowest = LVL_FULL;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (level_i[i] < lowest) begin
        lowest = level_i[i];
      end
    end
  end

  always_comb begin
    status_o.lowest_level = lowest;
    status_o.cutoff       = (lowest == LVL_CUTOFF);
    case (lowest)
      LVL_FULL: begin
        status_o.led_a = LED_GREEN;
        status_o.led_b = LED_GREEN;
      end
      LVL_80: begin
        status_o.led_a = LED_GREEN;
        status_o.led_b = LED_OFF;
      end
      LVL_60: begin
        status_o.led_a = LED_ORANGE;
        status_o.led_b = LED_ORANGE;
      end
      LVL_40: begin
        status_o.led_a = LED_ORANGE;
        status_o.led_b = LED_OFF;
      end
      LVL_20: begin
        status_o.led_a = LED_RED;
        status_o.led_b = LED_RED;
      end
      default: begin
        status_o.led_a = LED_OFF;
        status_o.led_b = LED_OFF;
      end
    endcase
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for battery_cell_monitor. ADC scans go in over a
// valid/ready channel, each accepted request is run through a local model of
// the mV scaling, current conversion, level classification and LED coding,
// and every result is compared field by field in arrival order. Thresholds
// and Rout are reprogrammed over APB between phases; both channel ends idle
// at random, and one phase holds the output off long enough to back up the
// input.
// ----------------------------------------------------------------------------
module tb_top;
  import bcm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned MAX_PRINTS     = 40;
  localparam logic [2:0]  REG_SPARE_A    = 3'd6;
  localparam logic [2:0]  REG_SPARE_B    = 3'd7;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  bcm_stream_if #(.T(in_t))  scan_if ();
  bcm_stream_if #(.T(out_t)) rpt_if ();

  battery_cell_monitor uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (scan_if),
    .out_o   (rpt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t        thr_cfg;
  out_t        reading_q[$];
  int unsigned err_cnt     = 0;
  int unsigned scans_sent  = 0;
  int unsigned rpts_seen   = 0;
  int unsigned cfg_writes  = 0;
  int unsigned idle_cycles = 0;
  int          hold_left   = 0;
  bit          gaps_on     = 1'b1;
  bit          quiet       = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic int unsigned adc_mv(logic [11:0] a);
    int unsigned x;
    x = 32'(a);
    return (x * 3300) / 4095;
  endfunction

  function automatic int unsigned tap_mv(logic [11:0] a);
    return (adc_mv(a) * 3) / 2;
  endfunction

  function automatic logic [2:0] level_of(int unsigned mv);
    if (mv < 100) return LVL_FULL;
    if (mv <= thr_cfg.cutoff_mv) return LVL_CUTOFF;
    if (mv <= thr_cfg.level20_mv) return LVL_20;
    if (mv <= thr_cfg.level40_mv) return LVL_40;
    if (mv <= thr_cfg.level60_mv) return LVL_60;
    if (mv <= thr_cfg.level80_mv) return LVL_80;
    return LVL_FULL;
  endfunction

  function automatic int unsigned rout_ohms(logic [1:0] sel);
    case (sel)
      2'd1:    return 5100;
      2'd2:    return 3400;
      2'd3:    return 2550;
      default: return 10200;
    endcase
  endfunction

  function automatic out_t predict_readings(in_t s);
    out_t        r;
    logic [11:0] taps [6];
    logic [12:0] mvs [6];
    logic [2:0]  lo;
    logic [2:0]  lv;
    taps[0] = s.cell1_adc;
    taps[1] = s.cell2_adc;
    taps[2] = s.cell3_adc;
    taps[3] = s.cell4_adc;
    taps[4] = s.cell5_adc;
    taps[5] = s.cell6_adc;
    lo = LVL_FULL;
    for (int i = 0; i < 6; i++) begin
      mvs[i] = 13'(tap_mv(taps[i]));
      lv = level_of(tap_mv(taps[i]));
      if (lv < lo) lo = lv;
    end
    r.cell1_mv = mvs[0];
    r.cell2_mv = mvs[1];
    r.cell3_mv = mvs[2];
    r.cell4_mv = mvs[3];
    r.cell5_mv = mvs[4];
    r.cell6_mv = mvs[5];
    r.reg_current_ma = 13'((adc_mv(s.reg_current_adc) * 51 * 200) / 5100);
    r.bat_current_ma = 18'((adc_mv(s.bat_current_adc) * 51 * 2000) /
                           rout_ohms(thr_cfg.rout_select));
    case (lo)
      LVL_FULL: begin r.led_a = LED_GREEN;  r.led_b = LED_GREEN;  end
      LVL_80:   begin r.led_a = LED_GREEN;  r.led_b = LED_OFF;    end
      LVL_60:   begin r.led_a = LED_ORANGE; r.led_b = LED_ORANGE; end
      LVL_40:   begin r.led_a = LED_ORANGE; r.led_b = LED_OFF;    end
      LVL_20:   begin r.led_a = LED_RED;    r.led_b = LED_RED;    end
      default:  begin r.led_a = LED_OFF;    r.led_b = LED_OFF;    end
    endcase
    r.lowest_level = lo;
    r.cutoff       = (lo == LVL_CUTOFF);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < MAX_PRINTS)
      $display("[%0t] result %0d %s: got %0d want %0d", $realtime, rpts_seen, what, got, want);
    err_cnt++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : rpt_check
    out_t got;
    out_t want;
    if (rst_ni && rpt_if.valid && rpt_if.ready) begin
      got = rpt_if.data;
      if (reading_q.size() == 0) begin
        report_mismatch("no pending request", 32'(got.lowest_level), 0);
      end else begin
        want = reading_q.pop_front();
        check_field("cell1_mv", 32'(got.cell1_mv), 32'(want.cell1_mv));
        check_field("cell2_mv", 32'(got.cell2_mv), 32'(want.cell2_mv));
        check_field("cell3_mv", 32'(got.cell3_mv), 32'(want.cell3_mv));
        check_field("cell4_mv", 32'(got.cell4_mv), 32'(want.cell4_mv));
        check_field("cell5_mv", 32'(got.cell5_mv), 32'(want.cell5_mv));
        check_field("cell6_mv", 32'(got.cell6_mv), 32'(want.cell6_mv));
        check_field("reg_current_ma", 32'(got.reg_current_ma), 32'(want.reg_current_ma));
        check_field("bat_current_ma", 32'(got.bat_current_ma), 32'(want.bat_current_ma));
        check_field("lowest_level", 32'(got.lowest_level), 32'(want.lowest_level));
        check_field("cutoff", 32'(got.cutoff), 32'(want.cutoff));
        check_field("led_a", 32'(got.led_a), 32'(want.led_a));
        check_field("led_b", 32'(got.led_b), 32'(want.led_b));
      end
      rpts_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((scan_if.valid && scan_if.ready) || (rpt_if.valid && rpt_if.ready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin : rpt_sink
    int stall;
    stall = 0;
    rpt_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rpt_if.ready <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        rpt_if.ready <= 1'b0;
        stall--;
      end else if (gaps_on && !quiet && $urandom_range(11) == 0) begin
        stall = $urandom_range(19, 1) - 1;
        rpt_if.ready <= 1'b0;
      end else begin
        rpt_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_scan(input in_t s);
    if (gaps_on && !quiet && $urandom_range(7) == 0) begin
      scan_if.valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk_i);
    end
    scan_if.valid <= 1'b1;
    scan_if.data  <= s;
    do @(posedge clk_i); while (!scan_if.ready);
    reading_q.push_back(predict_readings(s));
    scans_sent++;
  endtask

  task automatic wait_idle();
    scan_if.valid <= 1'b0;
    while (reading_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROUT:   thr_cfg.rout_select = val[1:0];
      REG_CUTOFF: thr_cfg.cutoff_mv   = val[12:0];
      REG_LVL20:  thr_cfg.level20_mv  = val[12:0];
      REG_LVL40:  thr_cfg.level40_mv  = val[12:0];
      REG_LVL60:  thr_cfg.level60_mv  = val[12:0];
      REG_LVL80:  thr_cfg.level80_mv  = val[12:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // upper bits are junk; only the register width must stick
  function automatic logic [31:0] with_junk(logic [12:0] v, int unsigned w);
    logic [31:0] r;
    r = $urandom;
    for (int i = 0; i < 13; i++)
      if (i < w) r[i] = v[i];
    return r;
  endfunction

  task automatic set_config(input logic [1:0] sel, input logic [12:0] c,
                            input logic [12:0] l20, input logic [12:0] l40,
                            input logic [12:0] l60, input logic [12:0] l80);
    write_reg(REG_ROUT, with_junk(13'(sel), 2));
    write_reg(REG_CUTOFF, with_junk(c, 13));
    write_reg(REG_LVL20, with_junk(l20, 13));
    write_reg(REG_LVL40, with_junk(l40, 13));
    write_reg(REG_LVL60, with_junk(l60, 13));
    write_reg(REG_LVL80, with_junk(l80, 13));
  endtask

  task automatic rand_config();
    logic [12:0] c;
    logic [12:0] l20;
    logic [12:0] l40;
    logic [12:0] l60;
    logic [12:0] l80;
    if ($urandom_range(4) == 0) begin
      c   = 13'($urandom_range(8191));
      l20 = 13'($urandom_range(8191));
      l40 = 13'($urandom_range(8191));
      l60 = 13'($urandom_range(8191));
      l80 = 13'($urandom_range(8191));
    end else begin
      c   = 13'($urandom_range(3500, 2800));
      l20 = 13'(c + $urandom_range(250));
      l40 = 13'(l20 + $urandom_range(250));
      l60 = 13'(l40 + $urandom_range(250));
      l80 = 13'(l60 + $urandom_range(250));
    end
    set_config(2'($urandom_range(3)), c, l20, l40, l60, l80);
  endtask

  // ---------------------------------------------------------------- scans
  function automatic in_t set_tap(in_t s, int k, logic [11:0] a);
    case (k)
      0:       s.cell1_adc = a;
      1:       s.cell2_adc = a;
      2:       s.cell3_adc = a;
      3:       s.cell4_adc = a;
      4:       s.cell5_adc = a;
      default: s.cell6_adc = a;
    endcase
    return s;
  endfunction

  function automatic logic [11:0] rand_tap();
    case ($urandom_range(9))
      0:       return 12'($urandom_range(120));
      1, 2, 3: return 12'($urandom_range(4095));
      default: return 12'($urandom_range(3500, 2400));
    endcase
  endfunction

  function automatic in_t rand_scan();
    in_t s;
    for (int k = 0; k < 6; k++) s = set_tap(s, k, rand_tap());
    s.reg_current_adc = 12'($urandom_range(4095));
    s.bat_current_adc = 12'($urandom_range(4095));
    return s;
  endfunction

  // all taps at full scale except one
  function automatic in_t one_low(int k, logic [11:0] a);
    in_t s;
    s = rand_scan();
    for (int i = 0; i < 6; i++) s = set_tap(s, i, 12'hFFF);
    return set_tap(s, k, a);
  endfunction

  // largest sample whose cell voltage does not exceed mv
  function automatic logic [11:0] adc_at_most(int unsigned mv);
    for (int a = 4095; a >= 0; a--)
      if (tap_mv(12'(a)) <= mv) return 12'(a);
    return '0;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    in_t         s;
    logic [12:0] th [5];
    logic [11:0] a;
    s = '0;
    send_scan(s);
    s = '1;
    send_scan(s);
    a = adc_at_most(99);
    send_scan(one_low(0, a));
    send_scan(one_low(1, a + 12'd1));
    th[0] = thr_cfg.cutoff_mv;
    th[1] = thr_cfg.level20_mv;
    th[2] = thr_cfg.level40_mv;
    th[3] = thr_cfg.level60_mv;
    th[4] = thr_cfg.level80_mv;
    for (int i = 0; i < 5; i++) begin
      a = adc_at_most(32'(th[i]));
      send_scan(one_low(i % 6, a));
      send_scan(one_low((i + 1) % 6, a + 12'd1));
    end
    for (int k = 0; k < 6; k++) send_scan(one_low(k, adc_at_most(32'(th[0]))));
  endtask

  task automatic test_rout_settings();
    in_t s;
    for (int sel = 0; sel < 4; sel++) begin
      wait_idle();
      write_reg(REG_ROUT, with_junk(13'(sel), 2));
      for (int j = 0; j < 8; j++) begin
        s = rand_scan();
        case (j)
          0:       s.bat_current_adc = '0;
          1:       s.bat_current_adc = '1;
          2:       s.bat_current_adc = 12'h800;
          default: ;
        endcase
        send_scan(s);
      end
    end
  endtask

  task automatic test_threshold_extremes();
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      case (p)
        0: set_config(2'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
        1: set_config(2'd3, 13'd4950, 13'd4950, 13'd4950, 13'd4950, 13'd4950);
        2: set_config(2'd1, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        3: set_config(2'd2, 13'd3900, 13'd3700, 13'd4950, 13'd3100, 13'd3400);
        default: begin
          set_config(2'd0, 13'd3300, 13'd3500, 13'd3650, 13'd3800, 13'd3950);
          write_reg(REG_SPARE_A, $urandom);
          write_reg(REG_SPARE_B, $urandom);
        end
      endcase
      for (int j = 0; j < 50; j++) send_scan(rand_scan());
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    gaps_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    for (int j = 0; j < 80; j++) send_scan(rand_scan());
    gaps_on = 1'b1;
  endtask

  task automatic test_random_configs();
    for (int k = 0; k < 6; k++) begin
      wait_idle();
      rand_config();
      gaps_on = ($urandom_range(3) != 0);
      for (int j = 0; j < 230; j++) send_scan(rand_scan());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_streaming();
    wait_idle();
    quiet = 1'b1;
    rand_config();
    for (int j = 0; j < 150; j++) send_scan(rand_scan());
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    thr_cfg.rout_select = 2'd0;
    thr_cfg.cutoff_mv   = 13'd3300;
    thr_cfg.level20_mv  = 13'd3500;
    thr_cfg.level40_mv  = 13'd3650;
    thr_cfg.level60_mv  = 13'd3800;
    thr_cfg.level80_mv  = 13'd3950;
    scan_if.valid <= 1'b0;
    scan_if.data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_rout_settings();
    test_threshold_extremes();
    test_backpressure();
    test_random_configs();
    test_streaming();
    wait_idle();

    $display("Ran %0d scans, checked %0d results, %0d register writes", scans_sent,
             rpts_seen, cfg_writes);
    $display("Covered level boundaries, absent cells, all Rout settings and a long output stall");
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
